// ===== hdl/htz_pkg.sv =====
// shared types, widths and level-base function for the hilbert tile id converter
package htz_pkg;

  localparam int ID_W      = 64;
  localparam int ZOOM_W    = 5;
  localparam int XY_W      = 31;
  localparam int POS_W     = 62;
  localparam int QK_W      = 64;
  // hilbert levels resolved per pipeline stage
  localparam int LEVELS_PER_STAGE = 8;

  // item as it moves through the hilbert decode stages
  typedef struct packed {
    logic              in_range;
    logic [ZOOM_W-1:0] zoom;
    logic [POS_W-1:0]  pos;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
  } htz_work_t;

  // first identifier of zoom level z: sum of 4^k for k < z
  function automatic logic [ID_W-1:0] level_base(input int unsigned z);
    logic [ID_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < ID_W / 2; k++) begin
      if (k < z) begin
        acc = acc | (ID_W'(1) << (2 * k));
      end
    end
    return acc;
  endfunction

endpackage

// ===== hdl/htz_if.sv =====
// valid/ready channel interfaces for tile identifiers and decoded tiles
interface htz_in_if;
  logic                    valid;
  logic                    ready;
  logic [htz_pkg::ID_W-1:0] tile_id;

  modport source(output valid, output tile_id, input ready);
  modport sink(input valid, input tile_id, output ready);
endinterface

interface htz_out_if;
  logic                      valid;
  logic                      ready;
  logic [htz_pkg::ZOOM_W-1:0] zoom;
  logic [htz_pkg::XY_W-1:0]   tile_x;
  logic [htz_pkg::XY_W-1:0]   tile_y;
  logic [htz_pkg::QK_W-1:0]   quadkey;
  logic                      in_range;

  modport source(output valid, output zoom, output tile_x, output tile_y,
                 output quadkey, output in_range, input ready);
  modport sink(input valid, input zoom, input tile_x, input tile_y,
               input quadkey, input in_range, output ready);
endinterface

// ===== hdl/htz_hilbert_stage.sv =====
// one pipeline stage of the hilbert decode: a group of rotate/reflect levels
module htz_hilbert_stage #(
  parameter int FIRST    = 0,
  parameter int LEVELS   = 8,
  parameter int MAX_ZOOM = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  htz_pkg::htz_work_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output htz_pkg::htz_work_t out_item
);

  logic               valid_r;
  htz_pkg::htz_work_t item_r;
  htz_pkg::htz_work_t item_nxt;

  // rotate and reflect for each level of this group that lies below the zoom
  always_comb begin
    logic                     bx;
    logic                     by;
    logic [htz_pkg::XY_W-1:0] mask;
    logic [htz_pkg::XY_W-1:0] t;
    bx       = 1'b0;
    by       = 1'b0;
    mask     = '0;
    t        = '0;
    item_nxt = in_item;
    for (int k = FIRST; k < FIRST + LEVELS && k < MAX_ZOOM; k++) begin
      if (k < int'(in_item.zoom)) begin
        bx   = in_item.pos[2 * k + 1];
        by   = in_item.pos[2 * k] ^ bx;
        mask = (htz_pkg::XY_W'(1) << k) - htz_pkg::XY_W'(1);
        if (!by) begin
          if (bx) begin
            item_nxt.x = item_nxt.x ^ mask;
            item_nxt.y = item_nxt.y ^ mask;
          end
          t          = item_nxt.x;
          item_nxt.x = item_nxt.y;
          item_nxt.y = t;
        end
        item_nxt.x[k] = bx;
        item_nxt.y[k] = by;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== hdl/hilbert_tile_id_to_zxy_quadkey_core.sv =====
// top level: tile identifier to zoom, column, row and quadkey converter
// Accepts one 64-bit cumulative Hilbert tile identifier per cycle and returns
// zoom, tile_x, tile_y, quadkey and in_range for each, in order. The block is
// a fully pipelined valid/ready chain: level compare, zoom/offset subtract,
// ceil(MAX_ZOOM/8) hilbert stages of eight rotate/reflect levels each, and an
// output register with the quadkey. Sustained throughput is one transaction
// per cycle; back-pressure on the output stalls the chain without loss.
// Identifiers at or above the first id past MAX_ZOOM give in_range 0 and all
// other fields 0.
module hilbert_tile_id_to_zxy_quadkey_core #(
  parameter int MAX_ZOOM = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  htz_in_if.sink    in_ch,
  htz_out_if.source out_ch
);

  localparam int NUM_HSTG =
    (MAX_ZOOM + htz_pkg::LEVELS_PER_STAGE - 1) / htz_pkg::LEVELS_PER_STAGE;

  // stage 1: compare against every level base
  logic                      s1_valid_r;
  logic                      s1_ready;
  logic [htz_pkg::ID_W-1:0]  s1_id_r;
  logic [MAX_ZOOM:0]         s1_ge_r;
  logic [MAX_ZOOM:0]         s1_ge_nxt;

  // stage 2: zoom and offset within the level
  logic                      s2_valid_r;
  logic                      s2_ready;
  htz_pkg::htz_work_t        s2_item_r;
  htz_pkg::htz_work_t        s2_item_nxt;

  // hilbert chain
  logic [NUM_HSTG:0]         h_valid;
  logic [NUM_HSTG:0]         h_ready;
  htz_pkg::htz_work_t        h_item [NUM_HSTG+1];

  // output register
  logic                      out_valid_r;
  logic                      out_ready_int;
  logic [htz_pkg::ZOOM_W-1:0] out_zoom_r;
  logic [htz_pkg::XY_W-1:0]   out_x_r;
  logic [htz_pkg::XY_W-1:0]   out_y_r;
  logic [htz_pkg::QK_W-1:0]   out_qk_r;
  logic [htz_pkg::QK_W-1:0]   out_qk_nxt;
  logic                      out_range_r;

  // level compares, entry j set when base of level j+1 <= id
  always_comb begin
    for (int j = 0; j <= MAX_ZOOM; j++) begin
      s1_ge_nxt[j] = in_ch.tile_id >= htz_pkg::level_base(j + 1);
    end
  end

  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_id_r <= in_ch.tile_id;
      s1_ge_r <= s1_ge_nxt;
    end
  end

  // zoom from the compare thermometer, then subtract the level base
  always_comb begin
    logic [htz_pkg::ID_W-1:0]  base;
    logic [htz_pkg::ID_W-1:0]  diff;
    logic [htz_pkg::ZOOM_W-1:0] z;
    base = '0;
    z    = '0;
    for (int j = 0; j < MAX_ZOOM; j++) begin
      if (s1_ge_r[j]) begin
        z    = htz_pkg::ZOOM_W'(j + 1);
        base = htz_pkg::level_base(j + 1);
      end
    end
    diff                 = s1_id_r - base;
    s2_item_nxt.in_range = !s1_ge_r[MAX_ZOOM];
    s2_item_nxt.zoom     = s1_ge_r[MAX_ZOOM] ? '0 : z;
    s2_item_nxt.pos      = s1_ge_r[MAX_ZOOM] ? '0 : diff[htz_pkg::POS_W-1:0];
    s2_item_nxt.x        = '0;
    s2_item_nxt.y        = '0;
  end

  assign s2_ready = !s2_valid_r || h_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign h_valid[0] = s2_valid_r;
  assign h_item[0]  = s2_item_r;

  // hilbert decode stages
  for (genvar i = 0; i < NUM_HSTG; i++) begin : g_hstg
    htz_hilbert_stage #(
      .FIRST    (i * htz_pkg::LEVELS_PER_STAGE),
      .LEVELS   (htz_pkg::LEVELS_PER_STAGE),
      .MAX_ZOOM (MAX_ZOOM)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (h_valid[i]),
      .in_ready  (h_ready[i]),
      .in_item   (h_item[i]),
      .out_valid (h_valid[i+1]),
      .out_ready (h_ready[i+1]),
      .out_item  (h_item[i+1])
    );
  end

  // quadkey: prefix 0b11 above the interleaved (y, x) digits
  always_comb begin
    htz_pkg::htz_work_t it;
    it         = h_item[NUM_HSTG];
    out_qk_nxt = htz_pkg::QK_W'(3) << {it.zoom, 1'b0};
    for (int i = 0; i < htz_pkg::XY_W; i++) begin
      out_qk_nxt[2 * i + 1] = out_qk_nxt[2 * i + 1] | it.y[i];
      out_qk_nxt[2 * i]     = out_qk_nxt[2 * i] | it.x[i];
    end
    if (!it.in_range) begin
      out_qk_nxt = '0;
    end
  end

  assign out_ready_int     = !out_valid_r || out_ch.ready;
  assign h_ready[NUM_HSTG] = out_ready_int;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_r <= h_valid[NUM_HSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int && h_valid[NUM_HSTG]) begin
      out_zoom_r  <= h_item[NUM_HSTG].zoom;
      out_x_r     <= h_item[NUM_HSTG].x;
      out_y_r     <= h_item[NUM_HSTG].y;
      out_qk_r    <= out_qk_nxt;
      out_range_r <= h_item[NUM_HSTG].in_range;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.zoom     = out_zoom_r;
  assign out_ch.tile_x   = out_x_r;
  assign out_ch.tile_y   = out_y_r;
  assign out_ch.quadkey  = out_qk_r;
  assign out_ch.in_range = out_range_r;

endmodule
